// ===== sv/lcmt_pkg.sv =====
// Shared constants, codes and types for the link cluster merge tracker.
// No dependencies; every other file of the block refers to this package.
package lcmt_pkg;

   // Default sizing of the node and label tables
   localparam int NODE_COUNT_DEFAULT  = 1024;
   localparam int LABEL_COUNT_DEFAULT = 512;

   // Transaction field widths
   localparam int OPCODE_W      = 1;
   localparam int NODE_FIELD_W  = 10;
   localparam int STATUS_W      = 2;
   localparam int KIND_W        = 2;
   localparam int LABEL_FIELD_W = 9;
   localparam int SIZE_FIELD_W  = 11;
   localparam int COUNT_FIELD_W = 16;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [KIND_W-1:0]   kind_type;

   // Opcodes
   localparam opcode_type OP_PLACE = 1'b0;
   localparam opcode_type OP_CLEAR = 1'b1;

   // Result status codes
   localparam status_type STATUS_PLACED    = 2'd0;
   localparam status_type STATUS_REJ_LIMIT = 2'd1;
   localparam status_type STATUS_CLEARED   = 2'd2;
   localparam status_type STATUS_REJ_EQUAL = 2'd3;

   // Event kinds
   localparam kind_type KIND_NEW      = 2'd0;
   localparam kind_type KIND_GROW     = 2'd1;
   localparam kind_type KIND_INTERNAL = 2'd2;
   localparam kind_type KIND_MERGE    = 2'd3;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_MAX_LINKS = 1'b0;
   localparam logic [COUNT_FIELD_W-1:0] MAX_LINKS_RESET = 16'd4095;

endpackage

// ===== sv/lcmt_req_if.sv =====
// Request channel of the link cluster merge tracker: valid/ready plus the link fields.
// Depends on lcmt_pkg.
interface lcmt_req_if;
   logic                               valid;
   logic                               ready;
   lcmt_pkg::opcode_type               opcode;
   logic [lcmt_pkg::NODE_FIELD_W-1:0]  node_a;
   logic [lcmt_pkg::NODE_FIELD_W-1:0]  node_b;

   modport source (output valid, opcode, node_a, node_b, input ready);
   modport sink   (input valid, opcode, node_a, node_b, output ready);
endinterface

// ===== sv/lcmt_rsp_if.sv =====
// Response channel of the link cluster merge tracker: valid/ready plus the result fields.
// Depends on lcmt_pkg.
interface lcmt_rsp_if;
   logic                                valid;
   logic                                ready;
   lcmt_pkg::status_type                status;
   lcmt_pkg::kind_type                  event_kind;
   logic [lcmt_pkg::LABEL_FIELD_W-1:0]  link_label;
   logic [lcmt_pkg::SIZE_FIELD_W-1:0]   cluster_size;
   logic [lcmt_pkg::SIZE_FIELD_W-1:0]   largest_size;
   logic [lcmt_pkg::SIZE_FIELD_W-1:0]   connected_count;
   logic [lcmt_pkg::COUNT_FIELD_W-1:0]  occupied_count;
   logic                                self_jump;

   modport source (output valid, status, event_kind, link_label, cluster_size, largest_size,
                   connected_count, occupied_count, self_jump, input ready);
   modport sink   (input valid, status, event_kind, link_label, cluster_size, largest_size,
                   connected_count, occupied_count, self_jump, output ready);
endinterface

// ===== sv/lcmt_csr.sv =====
// APB-style register block holding the max_links limit.
// Depends on lcmt_pkg.
module lcmt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lcmt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lcmt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lcmt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [lcmt_pkg::COUNT_FIELD_W-1:0]  max_links
);

   logic [lcmt_pkg::REG_IDX_W-1:0]      reg_idx;
   logic                                wr_max_links;
   logic [lcmt_pkg::COUNT_FIELD_W-1:0]  max_links_ff;
   logic [lcmt_pkg::COUNT_FIELD_W-1:0]  max_links_in;

   assign reg_idx      = paddr[lcmt_pkg::CSR_ADDR_W-1:2];
   assign wr_max_links = psel && penable && pwrite && (reg_idx == lcmt_pkg::REG_MAX_LINKS);
   assign max_links_in = wr_max_links ? pwdata[lcmt_pkg::COUNT_FIELD_W-1:0] : max_links_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_links_ff <= lcmt_pkg::MAX_LINKS_RESET;
      end else begin
         max_links_ff <= max_links_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == lcmt_pkg::REG_MAX_LINKS) begin
         prdata[lcmt_pkg::COUNT_FIELD_W-1:0] = max_links_ff;
      end
   end

   assign pready    = 1'b1;
   assign max_links = max_links_ff;

endmodule

// ===== sv/lcmt_engine.sv =====
// Cluster engine: node label memory, cluster size memory, sequencer and response register.
// Depends on lcmt_pkg, lcmt_req_if and lcmt_rsp_if.
module lcmt_engine #(
   parameter int NODE_COUNT  = lcmt_pkg::NODE_COUNT_DEFAULT,
   parameter int LABEL_COUNT = lcmt_pkg::LABEL_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   lcmt_req_if.sink                            req_chan,
   lcmt_rsp_if.source                          rsp_chan,
   input  logic [lcmt_pkg::COUNT_FIELD_W-1:0]  max_links
);

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int LAB_W  = $clog2(LABEL_COUNT);
   localparam int SZ_W   = $clog2(NODE_COUNT + 1);
   localparam int ENT_W  = LAB_W + 1;       // {valid, label}
   localparam int CNT_W  = NODE_W + 1;
   localparam int EXT_W  = NODE_W + lcmt_pkg::NODE_FIELD_W;
   localparam int CW     = lcmt_pkg::COUNT_FIELD_W;

   localparam logic [2:0] ST_SWEEP   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_RD_NODE = 3'd2;
   localparam logic [2:0] ST_EVAL    = 3'd3;
   localparam logic [2:0] ST_WR_B    = 3'd4;
   localparam logic [2:0] ST_SCAN    = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   // Memories
   logic [ENT_W-1:0]  node_mem [NODE_COUNT];
   logic [SZ_W-1:0]   size_mem [LABEL_COUNT];

   logic              node_we, node_re;
   logic [NODE_W-1:0] node_wa, node_ra_a, node_ra_b;
   logic [ENT_W-1:0]  node_wd, node_qa_ff, node_qb_ff;
   logic              size_we, size_re;
   logic [LAB_W-1:0]  size_wa, size_ra_a, size_ra_b;
   logic [SZ_W-1:0]   size_wd, size_qa_ff, size_qb_ff;

   // Control state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              sweep_report_ff, sweep_report_in;
   logic [LAB_W:0]    next_label_ff, next_label_in;
   logic [SZ_W-1:0]   connected_ff, connected_in;
   logic [SZ_W-1:0]   largest_ff, largest_in;
   logic [CW-1:0]     placed_ff, placed_in;
   logic [LAB_W-1:0]  prev_label_ff, prev_label_in;
   logic              prev_valid_ff, prev_valid_in;
   logic              scan_pend_ff, scan_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Per-transaction payload
   logic [NODE_W-1:0]        node_a_ff, node_a_in, node_b_ff, node_b_in;
   logic [NODE_W-1:0]        scan_addr_ff, scan_addr_in;
   logic [LAB_W-1:0]         gone_ff, gone_in;
   lcmt_pkg::status_type     res_status_ff, res_status_in;
   lcmt_pkg::kind_type       res_kind_ff, res_kind_in;
   logic [LAB_W-1:0]         res_label_ff, res_label_in;
   logic [SZ_W-1:0]          res_size_ff, res_size_in;

   // Response register
   lcmt_pkg::status_type                  rsp_status_ff, rsp_status_in;
   lcmt_pkg::kind_type                    rsp_kind_ff, rsp_kind_in;
   logic [lcmt_pkg::LABEL_FIELD_W-1:0]    rsp_label_ff, rsp_label_in;
   logic [lcmt_pkg::SIZE_FIELD_W-1:0]     rsp_size_ff, rsp_size_in;
   logic [lcmt_pkg::SIZE_FIELD_W-1:0]     rsp_largest_ff, rsp_largest_in;
   logic [lcmt_pkg::SIZE_FIELD_W-1:0]     rsp_connected_ff, rsp_connected_in;
   logic [CW-1:0]                         rsp_occupied_ff, rsp_occupied_in;
   logic                                  rsp_jump_ff, rsp_jump_in;

   // Combinational helpers
   logic [EXT_W-1:0]   a_ext, b_ext;
   logic [NODE_W-1:0]  req_a_idx, req_b_idx;
   logic               a_ok, b_ok;
   logic               va, vb;
   logic [LAB_W-1:0]   la, lb, keep_lab;
   logic [SZ_W-1:0]    size_sum;
   logic               placed_item, grow_largest, jump_new;
   logic [SZ_W-1:0]    largest_new;
   logic [CW-1:0]      placed_new;
   logic [LAB_W+lcmt_pkg::LABEL_FIELD_W-1:0]  label_ext;
   logic [SZ_W+lcmt_pkg::SIZE_FIELD_W-1:0]    size_ext, largest_ext, connected_ext;
   logic               rsp_free;

   assign a_ext     = {{NODE_W{1'b0}}, req_chan.node_a};
   assign b_ext     = {{NODE_W{1'b0}}, req_chan.node_b};
   assign req_a_idx = a_ext[NODE_W-1:0];
   assign req_b_idx = b_ext[NODE_W-1:0];
   assign a_ok      = a_ext < EXT_W'(NODE_COUNT);
   assign b_ok      = b_ext < EXT_W'(NODE_COUNT);

   assign va       = node_qa_ff[ENT_W-1];
   assign vb       = node_qb_ff[ENT_W-1];
   assign la       = node_qa_ff[LAB_W-1:0];
   assign lb       = node_qb_ff[LAB_W-1:0];
   assign size_sum = size_qa_ff + size_qb_ff;
   // larger cluster survives; node_b's cluster on a tie
   assign keep_lab = (size_qa_ff > size_qb_ff) ? la : lb;

   assign placed_item  = res_status_ff == lcmt_pkg::STATUS_PLACED;
   assign grow_largest = placed_item && (res_size_ff > largest_ff);
   assign largest_new  = grow_largest ? res_size_ff : largest_ff;
   assign jump_new     = grow_largest && prev_valid_ff && (prev_label_ff == res_label_ff);
   assign placed_new   = placed_item ? placed_ff + CW'(1) : placed_ff;

   assign label_ext     = {{lcmt_pkg::LABEL_FIELD_W{1'b0}}, res_label_ff};
   assign size_ext      = {{lcmt_pkg::SIZE_FIELD_W{1'b0}}, res_size_ff};
   assign largest_ext   = {{lcmt_pkg::SIZE_FIELD_W{1'b0}}, largest_new};
   assign connected_ext = {{lcmt_pkg::SIZE_FIELD_W{1'b0}}, connected_ff};

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      sweep_report_in  = sweep_report_ff;
      next_label_in    = next_label_ff;
      connected_in     = connected_ff;
      largest_in       = largest_ff;
      placed_in        = placed_ff;
      prev_label_in    = prev_label_ff;
      prev_valid_in    = prev_valid_ff;
      scan_pend_in     = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      node_a_in        = node_a_ff;
      node_b_in        = node_b_ff;
      scan_addr_in     = scan_addr_ff;
      gone_in          = gone_ff;
      res_status_in    = res_status_ff;
      res_kind_in      = res_kind_ff;
      res_label_in     = res_label_ff;
      res_size_in      = res_size_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_label_in     = rsp_label_ff;
      rsp_size_in      = rsp_size_ff;
      rsp_largest_in   = rsp_largest_ff;
      rsp_connected_in = rsp_connected_ff;
      rsp_occupied_in  = rsp_occupied_ff;
      rsp_jump_in      = rsp_jump_ff;
      node_we          = 1'b0;
      node_wa          = node_a_ff;
      node_wd          = '0;
      node_re          = 1'b0;
      node_ra_a        = req_a_idx;
      node_ra_b        = req_b_idx;
      size_we          = 1'b0;
      size_wa          = keep_lab;
      size_wd          = size_sum;
      size_re          = 1'b0;
      size_ra_a        = la;
      size_ra_b        = lb;
      req_chan.ready   = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            node_we = 1'b1;
            node_wa = cnt_ff[NODE_W-1:0];
            node_wd = '0;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NODE_COUNT - 1)) begin
               state_in = sweep_report_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               node_a_in    = req_a_idx;
               node_b_in    = req_b_idx;
               res_kind_in  = lcmt_pkg::KIND_NEW;
               res_label_in = '0;
               res_size_in  = '0;
               if (req_chan.opcode == lcmt_pkg::OP_CLEAR) begin
                  next_label_in   = '0;
                  connected_in    = '0;
                  largest_in      = '0;
                  placed_in       = '0;
                  prev_valid_in   = 1'b0;
                  cnt_in          = '0;
                  sweep_report_in = 1'b1;
                  res_status_in   = lcmt_pkg::STATUS_CLEARED;
                  state_in        = ST_SWEEP;
               end else if (placed_ff >= max_links || !a_ok || !b_ok) begin
                  res_status_in = lcmt_pkg::STATUS_REJ_LIMIT;
                  state_in      = ST_DONE;
               end else if (req_chan.node_a == req_chan.node_b) begin
                  res_status_in = lcmt_pkg::STATUS_REJ_EQUAL;
                  state_in      = ST_DONE;
               end else begin
                  res_status_in = lcmt_pkg::STATUS_PLACED;
                  node_re       = 1'b1;
                  state_in      = ST_RD_NODE;
               end
            end
         end
         ST_RD_NODE: begin
            // label fetch from node memory is back; fetch both cluster sizes
            size_re  = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!va && !vb) begin
               if (next_label_ff >= (LAB_W + 1)'(LABEL_COUNT)) begin
                  // out of labels
                  res_status_in = lcmt_pkg::STATUS_REJ_LIMIT;
                  state_in      = ST_DONE;
               end else begin
                  size_we       = 1'b1;
                  size_wa       = next_label_ff[LAB_W-1:0];
                  size_wd       = SZ_W'(2);
                  node_we       = 1'b1;
                  node_wa       = node_a_ff;
                  node_wd       = {1'b1, next_label_ff[LAB_W-1:0]};
                  next_label_in = next_label_ff + (LAB_W + 1)'(1);
                  connected_in  = connected_ff + SZ_W'(2);
                  res_kind_in   = lcmt_pkg::KIND_NEW;
                  res_label_in  = next_label_ff[LAB_W-1:0];
                  res_size_in   = SZ_W'(2);
                  state_in      = ST_WR_B;
               end
            end else if (va != vb) begin
               size_we      = 1'b1;
               size_wa      = va ? la : lb;
               size_wd      = (va ? size_qa_ff : size_qb_ff) + SZ_W'(1);
               node_we      = 1'b1;
               node_wa      = va ? node_b_ff : node_a_ff;
               node_wd      = {1'b1, (va ? la : lb)};
               connected_in = connected_ff + SZ_W'(1);
               res_kind_in  = lcmt_pkg::KIND_GROW;
               res_label_in = va ? la : lb;
               res_size_in  = (va ? size_qa_ff : size_qb_ff) + SZ_W'(1);
               state_in     = ST_DONE;
            end else if (la == lb) begin
               res_kind_in  = lcmt_pkg::KIND_INTERNAL;
               res_label_in = la;
               res_size_in  = size_qa_ff;
               state_in     = ST_DONE;
            end else begin
               // absorbed label keeps a stale size; no node holds it after the scan
               size_we      = 1'b1;
               size_wa      = keep_lab;
               size_wd      = size_sum;
               gone_in      = (size_qa_ff > size_qb_ff) ? lb : la;
               res_kind_in  = lcmt_pkg::KIND_MERGE;
               res_label_in = keep_lab;
               res_size_in  = size_sum;
               cnt_in       = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_WR_B: begin
            node_we  = 1'b1;
            node_wa  = node_b_ff;
            node_wd  = {1'b1, res_label_ff};
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // read entry n while relabelling entry n-1
            node_ra_a = cnt_ff[NODE_W-1:0];
            if (cnt_ff < CNT_W'(NODE_COUNT)) begin
               node_re      = 1'b1;
               cnt_in       = cnt_ff + CNT_W'(1);
               scan_pend_in = 1'b1;
               scan_addr_in = cnt_ff[NODE_W-1:0];
            end
            if (scan_pend_ff && va && (la == gone_ff)) begin
               node_we = 1'b1;
               node_wa = scan_addr_ff;
               node_wd = {1'b1, res_label_ff};
            end
            if (cnt_ff == CNT_W'(NODE_COUNT) && !scan_pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               largest_in       = largest_new;
               placed_in        = placed_new;
               if (placed_item) begin
                  prev_label_in = res_label_ff;
                  prev_valid_in = 1'b1;
               end
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_kind_in      = res_kind_ff;
               rsp_label_in     = label_ext[lcmt_pkg::LABEL_FIELD_W-1:0];
               rsp_size_in      = size_ext[lcmt_pkg::SIZE_FIELD_W-1:0];
               rsp_largest_in   = largest_ext[lcmt_pkg::SIZE_FIELD_W-1:0];
               rsp_connected_in = connected_ext[lcmt_pkg::SIZE_FIELD_W-1:0];
               rsp_occupied_in  = placed_new;
               rsp_jump_in      = jump_new;
               sweep_report_in  = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Node label memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      if (node_re) begin
         node_qa_ff <= node_mem[node_ra_a];
         node_qb_ff <= node_mem[node_ra_b];
      end
   end

   // Cluster size memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_wa] <= size_wd;
      end
      if (size_re) begin
         size_qa_ff <= size_mem[size_ra_a];
         size_qb_ff <= size_mem[size_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_SWEEP;
         cnt_ff          <= '0;
         sweep_report_ff <= 1'b0;
         next_label_ff   <= '0;
         connected_ff    <= '0;
         largest_ff      <= '0;
         placed_ff       <= '0;
         prev_label_ff   <= '0;
         prev_valid_ff   <= 1'b0;
         scan_pend_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         sweep_report_ff <= sweep_report_in;
         next_label_ff   <= next_label_in;
         connected_ff    <= connected_in;
         largest_ff      <= largest_in;
         placed_ff       <= placed_in;
         prev_label_ff   <= prev_label_in;
         prev_valid_ff   <= prev_valid_in;
         scan_pend_ff    <= scan_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_a_ff        <= node_a_in;
      node_b_ff        <= node_b_in;
      scan_addr_ff     <= scan_addr_in;
      gone_ff          <= gone_in;
      res_status_ff    <= res_status_in;
      res_kind_ff      <= res_kind_in;
      res_label_ff     <= res_label_in;
      res_size_ff      <= res_size_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_label_ff     <= rsp_label_in;
      rsp_size_ff      <= rsp_size_in;
      rsp_largest_ff   <= rsp_largest_in;
      rsp_connected_ff <= rsp_connected_in;
      rsp_occupied_ff  <= rsp_occupied_in;
      rsp_jump_ff      <= rsp_jump_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.event_kind      = rsp_kind_ff;
   assign rsp_chan.link_label      = rsp_label_ff;
   assign rsp_chan.cluster_size    = rsp_size_ff;
   assign rsp_chan.largest_size    = rsp_largest_ff;
   assign rsp_chan.connected_count = rsp_connected_ff;
   assign rsp_chan.occupied_count  = rsp_occupied_ff;
   assign rsp_chan.self_jump       = rsp_jump_ff;

endmodule

// ===== sv/link_cluster_merge_tracker_unit.sv =====
// Top level of the link cluster merge tracker: register block plus cluster engine.
// Depends on lcmt_pkg, lcmt_req_if, lcmt_rsp_if, lcmt_csr and lcmt_engine.
//
// Union-by-size cluster tracker with eager relabelling. Each request transaction
// either places a link between node_a and node_b, rejects it, or clears every
// cluster and counter; each request yields exactly one response transaction. Node
// labels live in a NODE_COUNT-entry memory and cluster sizes in a LABEL_COUNT-entry
// memory, both with registered reads. One request is worked at a time: a link reads
// both node labels, then both cluster sizes, then is evaluated; a link that opens a
// cluster also writes node_b's label afterwards. A link rejected for the limit, a
// node number or equal ends goes straight to the response. A merge walks the whole
// node memory one entry per cycle to relabel the absorbed cluster. A clear, and
// reset, sweep the node memory one entry per cycle; after reset no request is
// accepted until the sweep is done. The response register lets the next request be
// accepted while a response waits. max_links sits at byte address 0 of the APB
// port (reset 4095); write it only while no transaction is outstanding.
module link_cluster_merge_tracker_unit #(
   parameter int NODE_COUNT  = lcmt_pkg::NODE_COUNT_DEFAULT,
   parameter int LABEL_COUNT = lcmt_pkg::LABEL_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   lcmt_req_if.sink                         req_chan,
   lcmt_rsp_if.source                       rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lcmt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lcmt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lcmt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   logic [lcmt_pkg::COUNT_FIELD_W-1:0] max_links;

   // link limit register
   lcmt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .max_links (max_links)
   );

   // memories, sequencer and response register
   lcmt_engine #(
      .NODE_COUNT  (NODE_COUNT),
      .LABEL_COUNT (LABEL_COUNT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .max_links (max_links)
   );

endmodule

// ===== sv/lcmt_checker.sv =====
// Port-level assertions for the link cluster merge tracker, bound to the top level.
// Depends on lcmt_pkg and link_cluster_merge_tracker_unit.
module lcmt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input lcmt_pkg::status_type                rsp_status,
   input lcmt_pkg::kind_type                  rsp_kind,
   input logic [lcmt_pkg::LABEL_FIELD_W-1:0]  rsp_label,
   input logic [lcmt_pkg::SIZE_FIELD_W-1:0]   rsp_size,
   input logic [lcmt_pkg::SIZE_FIELD_W-1:0]   rsp_largest,
   input logic [lcmt_pkg::SIZE_FIELD_W-1:0]   rsp_connected,
   input logic [lcmt_pkg::COUNT_FIELD_W-1:0]  rsp_occupied,
   input logic                                rsp_jump
);

   // stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // only placed links carry link details
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lcmt_pkg::STATUS_PLACED |->
         rsp_kind == lcmt_pkg::KIND_NEW && rsp_label == '0 && rsp_size == '0 && !rsp_jump)
      else $error("rejected or cleared response carries link details");

   // a clear zeroes every counter
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lcmt_pkg::STATUS_CLEARED |->
         rsp_largest == '0 && rsp_connected == '0 && rsp_occupied == '0)
      else $error("counters not zero after clear");

   // size ordering of a placed link
   a_size_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lcmt_pkg::STATUS_PLACED |->
         rsp_size >= lcmt_pkg::SIZE_FIELD_W'(2) && rsp_size <= rsp_largest &&
         rsp_largest <= rsp_connected && rsp_occupied != '0)
      else $error("cluster size ordering broken");

   // a self jump always coincides with a new largest cluster
   a_jump_largest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_jump |-> rsp_largest == rsp_size)
      else $error("self jump without largest cluster");

endmodule

bind link_cluster_merge_tracker_unit lcmt_checker u_lcmt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_kind      (rsp_chan.event_kind),
   .rsp_label     (rsp_chan.link_label),
   .rsp_size      (rsp_chan.cluster_size),
   .rsp_largest   (rsp_chan.largest_size),
   .rsp_connected (rsp_chan.connected_count),
   .rsp_occupied  (rsp_chan.occupied_count),
   .rsp_jump      (rsp_chan.self_jump)
);
